// ----- hw/rtl/rbuf_pkg.sv -----
// Package for the byte ring buffer with overwrite.
// Holds the depth, derived widths and the action codes; no dependencies.
package rbuf_pkg;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned VALUE_W  = 8;

  // Slave tdata: value padded to whole bytes; slave tuser: action
  localparam int unsigned S_TDATA_W = ((VALUE_W + 7) / 8) * 8;
  localparam int unsigned S_TUSER_W = ACTION_W;

  // Master tdata: ok, data, overwrote, count, empty_res, full_res
  localparam int unsigned RES_W     = 1 + 8 + 1 + CNT_W + 1 + 1;
  localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FORCE_PUSH = 3'd0,
    ACT_SOFT_PUSH  = 3'd1,
    ACT_POP        = 3'd2,
    ACT_DROP       = 3'd3,
    ACT_FLUSH      = 3'd4
  } action_t;

endpackage

// ----- hw/rtl/byte_ring_buffer_overwrite_top.sv -----
// Byte ring buffer with forced/soft push, pop, drop and flush.
// Depends on rbuf_pkg for depth, widths and action codes.
//
//   channel | direction | payload
//   s_*     | in        | tuser: action[2:0]; tdata: value[7:0]
//   m_*     | out       | tdata: ok, data, overwrote, count, empty_res, full_res
//
// One transaction per cycle while s_tready is high: each action is decoded and
// the pointers updated in the cycle it is accepted; the result sits in the
// output register from the next cycle. The store is a single-port-write,
// single-read memory read at the read pointer. Reset (rst, synchronous)
// empties the buffer; store contents are not cleared. s_tready drops only
// while a result waits and m_tready is low.
module byte_ring_buffer_overwrite_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rbuf_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] value
  input  logic [rbuf_pkg::S_TUSER_W-1:0] s_tuser,  // [2:0] action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] ok, [8:1] data, [9] overwrote, [18:10] count, [19] empty_res,
  // [20] full_res, rest zero
  output logic [rbuf_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int unsigned PW = rbuf_pkg::PTR_W;
  localparam int unsigned CW = rbuf_pkg::CNT_W;

  logic [7:0]    store [rbuf_pkg::DEPTH];

  logic [PW-1:0] read_ptr, read_ptr_next;
  logic [PW-1:0] write_ptr, write_ptr_next;
  logic          is_empty, is_empty_next;

  logic          out_valid;
  logic          res_ok, res_pop, res_overwrote, res_empty, res_full;
  logic [CW-1:0] res_count;
  logic [7:0]    rd_data;

  logic          accept;
  logic          full_now;
  logic          wr_en;
  logic          ok_next, pop_next, overwrote_next, full_next;
  logic [CW-1:0] count_next;
  logic [PW-1:0] rp_inc;
  logic [7:0]    in_value;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign in_value = s_tdata[7:0];
  assign full_now = !is_empty && (read_ptr == write_ptr);
  assign rp_inc   = read_ptr + PW'(1);

  always_comb begin
    read_ptr_next  = read_ptr;
    write_ptr_next = write_ptr;
    is_empty_next  = is_empty;
    wr_en          = 1'b0;
    ok_next        = 1'b0;
    pop_next       = 1'b0;
    overwrote_next = 1'b0;
    unique case (rbuf_pkg::action_t'(s_tuser))
      rbuf_pkg::ACT_FORCE_PUSH: begin
        if (full_now) begin
          read_ptr_next  = rp_inc;
          overwrote_next = 1'b1;
        end
        wr_en          = 1'b1;
        write_ptr_next = write_ptr + PW'(1);
        is_empty_next  = 1'b0;
        ok_next        = 1'b1;
      end
      rbuf_pkg::ACT_SOFT_PUSH: begin
        if (!full_now) begin
          wr_en          = 1'b1;
          write_ptr_next = write_ptr + PW'(1);
          is_empty_next  = 1'b0;
          ok_next        = 1'b1;
        end
      end
      rbuf_pkg::ACT_POP: begin
        if (!is_empty) begin
          pop_next = 1'b1;
          ok_next  = 1'b1;
          if (rp_inc == write_ptr) begin
            // Last byte out: rewind both pointers
            read_ptr_next  = '0;
            write_ptr_next = '0;
            is_empty_next  = 1'b1;
          end else begin
            read_ptr_next = rp_inc;
          end
        end
      end
      rbuf_pkg::ACT_DROP: begin
        if (!is_empty) begin
          read_ptr_next = rp_inc;
          ok_next       = 1'b1;
          if (rp_inc == write_ptr) begin
            is_empty_next = 1'b1;
          end
        end
      end
      rbuf_pkg::ACT_FLUSH: begin
        read_ptr_next  = '0;
        write_ptr_next = '0;
        is_empty_next  = 1'b1;
        ok_next        = 1'b1;
      end
      default: begin
        // Unused codes: no change, report current state
      end
    endcase
  end

  assign full_next = !is_empty_next && (read_ptr_next == write_ptr_next);

  always_comb begin
    if (is_empty_next) begin
      count_next = '0;
    end else if (full_next) begin
      count_next = CW'(rbuf_pkg::DEPTH);
    end else begin
      count_next = {1'b0, PW'(write_ptr_next - read_ptr_next)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr  <= '0;
      write_ptr <= '0;
      is_empty  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        read_ptr  <= read_ptr_next;
        write_ptr <= write_ptr_next;
        is_empty  <= is_empty_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok        <= ok_next;
      res_pop       <= pop_next;
      res_overwrote <= overwrote_next;
      res_count     <= count_next;
      res_empty     <= is_empty_next;
      res_full      <= full_next;
    end
  end

  // Store: write at the write pointer, read at the read pointer
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      store[write_ptr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= store[read_ptr];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(rbuf_pkg::M_TDATA_W - rbuf_pkg::RES_W)'(0),
                     res_full, res_empty, res_count, res_overwrote,
                     (res_pop ? rd_data : 8'd0), res_ok};

  // An empty buffer always has coinciding pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    is_empty |-> (read_ptr == write_ptr))
    else $error("empty buffer with differing pointers");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == rbuf_pkg::ACT_POP && !is_empty)
      |=> (m_tvalid && m_tdata[0]))
    else $error("pop of a non-empty buffer not reported as success");

  a_soft_full: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == rbuf_pkg::ACT_SOFT_PUSH && full_now)
      |=> (!res_ok && res_full && $stable(write_ptr)))
    else $error("soft push into a full buffer was not rejected");

  a_flags_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((res_empty == (res_count == '0)) &&
                   (res_full == (res_count == CW'(rbuf_pkg::DEPTH)))))
    else $error("result flags disagree with count");

  a_overwrite_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_overwrote) |-> res_full)
    else $error("overwrite reported on a buffer that is not full");

endmodule

// ----- tb/byte_ring_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the byte ring buffer: watches both stream channels, keeps
// its own copy of the ring and compares every result. Depends on rbuf_pkg.
module byte_ring_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rbuf_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [rbuf_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [rbuf_pkg::M_TDATA_W-1:0] m_tdata,
  output int                             mismatches,
  output int                             pending,
  output int                             checked,
  output int                             overwrites,
  output int                             refusals,
  output int                             peak_fill
);

  localparam int unsigned PW = rbuf_pkg::PTR_W;
  localparam int unsigned CW = rbuf_pkg::CNT_W;

  // Packed so that ok lands in bit 0, as on m_tdata
  typedef struct packed {
    logic          full;
    logic          empty;
    logic [CW-1:0] count;
    logic          overwrote;
    logic [7:0]    data;
    logic          ok;
  } ring_result_t;

  logic [7:0]    ring_mem [rbuf_pkg::DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic [PW-1:0] span;
  logic          ring_empty;
  logic          was_full;
  ring_result_t  want;
  ring_result_t  got;
  ring_result_t  results_due [$];
  int            err_cnt;
  int            chk_cnt;
  int            ovw_cnt;
  int            ref_cnt;
  int            peak;

  initial begin
    err_cnt = 0;
    chk_cnt = 0;
    ovw_cnt = 0;
    ref_cnt = 0;
    peak    = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      head       = '0;
      tail       = '0;
      ring_empty = 1'b1;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = ring_result_t'(m_tdata[rbuf_pkg::RES_W-1:0]);
        if (results_due.size() == 0) begin
          err_cnt++;
          $display("%0t: result with nothing outstanding: ok=%0b data=%02h ovw=%0b count=%0d",
                   $time, got.ok, got.data, got.overwrote, got.count);
        end else begin
          want = results_due.pop_front();
          chk_cnt++;
          if (got !== want) begin
            err_cnt++;
            $display("%0t: result mismatch", $time);
            $display("  expected ok=%0b data=%02h ovw=%0b count=%0d empty=%0b full=%0b",
                     want.ok, want.data, want.overwrote, want.count, want.empty, want.full);
            $display("  actual   ok=%0b data=%02h ovw=%0b count=%0d empty=%0b full=%0b",
                     got.ok, got.data, got.overwrote, got.count, got.empty, got.full);
          end
        end
      end

      if (s_tvalid && s_tready) begin
        want     = '0;
        was_full = !ring_empty && head == tail;
        case (s_tuser)
          rbuf_pkg::ACT_FORCE_PUSH: begin
            // full: write over the oldest byte and advance both ends
            if (was_full) begin
              head           = head + PW'(1);
              want.overwrote = 1'b1;
            end
            ring_mem[tail] = s_tdata[7:0];
            tail           = tail + PW'(1);
            ring_empty     = 1'b0;
            want.ok        = 1'b1;
          end
          rbuf_pkg::ACT_SOFT_PUSH: begin
            if (!was_full) begin
              ring_mem[tail] = s_tdata[7:0];
              tail           = tail + PW'(1);
              ring_empty     = 1'b0;
              want.ok        = 1'b1;
            end
          end
          rbuf_pkg::ACT_POP: begin
            if (!ring_empty) begin
              want.data = ring_mem[head];
              head      = head + PW'(1);
              // last byte gone: rewind both pointers
              if (head == tail) begin
                head       = '0;
                tail       = '0;
                ring_empty = 1'b1;
              end
              want.ok = 1'b1;
            end
          end
          rbuf_pkg::ACT_DROP: begin
            // pointers are not rewound when the drop empties the ring
            if (!ring_empty) begin
              head = head + PW'(1);
              if (head == tail) ring_empty = 1'b1;
              want.ok = 1'b1;
            end
          end
          rbuf_pkg::ACT_FLUSH: begin
            head       = '0;
            tail       = '0;
            ring_empty = 1'b1;
            want.ok    = 1'b1;
          end
          default: begin
          end
        endcase
        span       = tail - head;
        want.empty = ring_empty;
        want.full  = !ring_empty && head == tail;
        want.count = ring_empty ? CW'(0) : want.full ? CW'(rbuf_pkg::DEPTH) : CW'(span);
        if (want.overwrote) ovw_cnt++;
        if (s_tuser == rbuf_pkg::ACT_SOFT_PUSH && !want.ok) ref_cnt++;
        if (int'(want.count) > peak) peak = int'(want.count);
        results_due.push_back(want);
      end
    end

    mismatches <= err_cnt;
    pending    <= results_due.size();
    checked    <= chk_cnt;
    overwrites <= ovw_cnt;
    refusals   <= ref_cnt;
    peak_fill  <= peak;
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the byte ring buffer top level.
// Depends on rbuf_pkg, byte_ring_buffer_overwrite_top and byte_ring_checker.
module testbench;

  localparam int unsigned AW = rbuf_pkg::ACTION_W;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [AW-1:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [AW-1:0] ACT_RESERVED_LAST  = 3'd7;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [rbuf_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic [rbuf_pkg::S_TUSER_W-1:0] s_tuser  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [rbuf_pkg::M_TDATA_W-1:0] m_tdata;

  int mismatches, pending, checked, overwrites, refusals, peak_fill;
  int unsigned s_gap_max = 11;
  int unsigned m_gap_max = 11;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int          actions_sent = 0;
  int          cycle_cnt = 0;

  always #5 clk = ~clk;

  byte_ring_buffer_overwrite_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  byte_ring_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .overwrites (overwrites),
    .refusals   (refusals),
    .peak_fill  (peak_fill)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("byte_ring_buffer_overwrite_top: mismatch");
      $finish;
    end
  end

  // Receiver: a long hold-off first, then the per-result stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) stall_left = $urandom_range(0, m_gap_max);
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send(input logic [AW-1:0] act, input logic [7:0] val);
    int unsigned gap;
    gap = $urandom_range(0, s_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    actions_sent++;
  endtask

  // Lower valid and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [AW-1:0] draw_action(input int unsigned push_pct,
                                                input int unsigned pop_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct)
      return ($urandom_range(0, 1) != 0) ? rbuf_pkg::ACT_FORCE_PUSH : rbuf_pkg::ACT_SOFT_PUSH;
    if (roll < push_pct + pop_pct)
      return ($urandom_range(0, 1) != 0) ? rbuf_pkg::ACT_POP : rbuf_pkg::ACT_DROP;
    return AW'($urandom_range(rbuf_pkg::ACT_FLUSH, ACT_RESERVED_LAST));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty-ring corners, pop that empties, drop that empties, flush
    send(rbuf_pkg::ACT_POP, 8'hFF);
    send(rbuf_pkg::ACT_DROP, 8'hFF);
    send(rbuf_pkg::ACT_SOFT_PUSH, 8'h00);
    send(rbuf_pkg::ACT_FORCE_PUSH, 8'hFF);
    send(rbuf_pkg::ACT_POP, 8'h00);
    send(rbuf_pkg::ACT_POP, 8'h00);
    send(rbuf_pkg::ACT_FORCE_PUSH, 8'hA5);
    send(rbuf_pkg::ACT_SOFT_PUSH, 8'h5A);
    send(rbuf_pkg::ACT_DROP, 8'h00);
    send(rbuf_pkg::ACT_DROP, 8'h00);
    send(rbuf_pkg::ACT_SOFT_PUSH, 8'h3C);
    send(rbuf_pkg::ACT_POP, 8'hFF);
    send(rbuf_pkg::ACT_FORCE_PUSH, 8'h81);
    send(rbuf_pkg::ACT_FLUSH, 8'hFF);
    send(rbuf_pkg::ACT_POP, 8'h00);
    send(rbuf_pkg::ACT_FORCE_PUSH, 8'h7E);
    for (int a = ACT_RESERVED_FIRST; a <= ACT_RESERVED_LAST; a++)
      send(AW'(a), 8'hFF);
    send(rbuf_pkg::ACT_FLUSH, 8'h00);
    send(rbuf_pkg::ACT_SOFT_PUSH, 8'hC3);
    send(rbuf_pkg::ACT_POP, 8'h00);
    drain();

    // fill past full: block the receiver first so the input stalls
    s_gap_max = 0;
    m_gap_max = 0;
    hold_left = 80;
    for (int i = 0; i < 300; i++) begin
      if (i == 150) begin
        s_gap_max = 11;
        m_gap_max = 11;
      end
      send(draw_action(97, 3), 8'($urandom_range(0, 255)));
    end
    drain();

    for (int i = 0; i < 60; i++) send(draw_action(25, 70), 8'($urandom_range(0, 255)));

    // churn near empty, receiver always ready
    m_gap_max = 0;
    for (int i = 0; i < 60; i++) send(draw_action(45, 47), 8'($urandom_range(0, 255)));
    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d actions: empty and full corners, reserved codes, %0d results checked.",
             actions_sent, checked);
    $display("Overwrites on full: %0d, soft pushes refused: %0d, peak fill: %0d bytes.",
             overwrites, refusals, peak_fill);
    if (mismatches == 0) begin
      $display("byte_ring_buffer_overwrite_top: match");
    end else begin
      $display("byte_ring_buffer_overwrite_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- byte_ring_buffer_overwrite_top.f -----
hw/rtl/rbuf_pkg.sv
hw/rtl/byte_ring_buffer_overwrite_top.sv
tb/byte_ring_checker.sv
tb/testbench.sv
